>>> rtl/iff_pkg.sv
// iff_pkg: shared types, codes and character constants for the integer field formatter
// used by iff_front, iff_queue, iff_back and integer_field_formatter_top; no dependencies
package iff_pkg;

  localparam logic [2:0] CONV_SDEC = 3'd0;
  localparam logic [2:0] CONV_UDEC = 3'd1;
  localparam logic [2:0] CONV_OCT  = 3'd2;
  localparam logic [2:0] CONV_HEXL = 3'd3;
  localparam logic [2:0] CONV_HEXU = 3'd4;
  localparam logic [2:0] CONV_PTR  = 3'd5;

  localparam logic [1:0] SIZE_32 = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;

  localparam int NDIG  = 22;
  localparam int BCD_W = 80;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_MINUS = 7'h2d;
  localparam logic [6:0] CH_PLUS  = 7'h2b;
  localparam logic [6:0] CH_XL    = 7'h78;
  localparam logic [6:0] CH_XU    = 7'h58;

  typedef enum logic [1:0] {BASE_DEC, BASE_OCT, BASE_HEX} base_t;

  typedef struct packed {
    logic [63:0] mag;
    logic        mag_zero;
    base_t       base;
    logic        upper;
    logic        ptr;
    logic [1:0]  plen;
    logic [6:0]  pre0;
    logic [6:0]  pre1;
    logic        left;
    logic        zf;
    logic        alt_oct;
    logic [6:0]  width;
    logic [5:0]  prec;
    logic        given;
  } desc_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {3'b0, d};
    end else if (upper) begin
      c = 7'h37 + {3'b0, d};
    end else begin
      c = 7'h57 + {3'b0, d};
    end
    return c;
  endfunction

endpackage

>>> rtl/integer_field_formatter_top.sv
// integer_field_formatter_top: printf-style integer field formatter, stream in and out
// depends on iff_pkg, iff_front, iff_queue, iff_back
//
// One input beat carries an integer and its conversion spec; the block returns the
// formatted field as one ASCII character per output beat, with tlast on the final one,
// and no beat at all for an empty field or an unknown conversion. Decimal values pass
// through the 64-step binary-to-BCD loop in the back end, while octal, hex and pointer
// values skip it; a two-entry queue lets the front accept new items while the back end
// is busy.
module integer_field_formatter_top import iff_pkg::*; #(
  parameter int MAX_FIELD = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value[63:0], left_justify, force_plus, space_sign, zero_fill, alt_form,
  // min_width[6:0], min_digits[5:0], digits_given, zero fill
  input  logic [87:0] in_tdata,
  // conversion[2:0], size_mod[1:0]
  input  logic [4:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // char_code[6:0], zero fill
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  desc_t      fdesc, qdesc;
  logic       known, qfull, qempty, qpop, push;
  logic [1:0] qcount;
  logic [6:0] ochar;

  iff_front u_front (
    .value        (in_tdata[63:0]),
    .conversion   (in_tuser[2:0]),
    .size_mod     (in_tuser[4:3]),
    .left_justify (in_tdata[64]),
    .force_plus   (in_tdata[65]),
    .space_sign   (in_tdata[66]),
    .zero_fill    (in_tdata[67]),
    .alt_form     (in_tdata[68]),
    .min_width    (in_tdata[75:69]),
    .min_digits   (in_tdata[81:76]),
    .digits_given (in_tdata[82]),
    .known        (known),
    .desc         (fdesc)
  );

  assign in_tready = !qfull;
  assign push      = in_tvalid && !qfull && known;

  iff_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (fdesc),
    .full      (qfull),
    .pop       (qpop),
    .pop_data  (qdesc),
    .empty     (qempty),
    .count     (qcount)
  );

  iff_back #(.MAX_FIELD(MAX_FIELD)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (qempty),
    .job        (qdesc),
    .pop        (qpop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (ochar),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, ochar};

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n) qcount != 2'd3)
    else $error("queue count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n) qfull |-> !in_tready)
    else $error("beat taken while queue full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) qpop |-> !qempty)
    else $error("pop from empty queue");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

>>> rtl/iff_front.sv
// iff_front: classifies one input beat into a job descriptor (size, sign, magnitude, prefix)
// depends on iff_pkg
module iff_front import iff_pkg::*; (
  input  logic [63:0] value,
  input  logic [2:0]  conversion,
  input  logic [1:0]  size_mod,
  input  logic        left_justify,
  input  logic        force_plus,
  input  logic        space_sign,
  input  logic        zero_fill,
  input  logic        alt_form,
  input  logic [6:0]  min_width,
  input  logic [5:0]  min_digits,
  input  logic        digits_given,
  output logic        known,
  output desc_t       desc
);

  logic        is64, is16, sbit, neg, hexc;
  logic [63:0] raw, negv, negm, mag;

  always_comb begin
    is64 = (conversion == CONV_PTR) || !((size_mod == SIZE_32) || (size_mod == SIZE_16));
    is16 = !is64 && (size_mod == SIZE_16);
    if (is64) begin
      raw  = value;
      sbit = value[63];
    end else if (is16) begin
      raw  = {48'b0, value[15:0]};
      sbit = value[15];
    end else begin
      raw  = {32'b0, value[31:0]};
      sbit = value[31];
    end
    negv = 64'd0 - raw;
    if (is64) negm = negv;
    else if (is16) negm = {48'b0, negv[15:0]};
    else negm = {32'b0, negv[31:0]};
    neg  = (conversion == CONV_SDEC) && sbit;
    mag  = neg ? negm : raw;
    hexc = (conversion == CONV_HEXL) || (conversion == CONV_HEXU);

    known         = conversion <= CONV_PTR;
    desc.mag      = mag;
    desc.mag_zero = (mag == 64'd0);
    desc.base     = (conversion == CONV_OCT) ? BASE_OCT :
                    (hexc || conversion == CONV_PTR) ? BASE_HEX : BASE_DEC;
    desc.upper    = (conversion == CONV_HEXU);
    desc.ptr      = (conversion == CONV_PTR);
    desc.plen     = 2'd0;
    desc.pre0     = CH_ZERO;
    desc.pre1     = (conversion == CONV_HEXU) ? CH_XU : CH_XL;
    if (conversion == CONV_SDEC) begin
      if (neg) begin
        desc.plen = 2'd1;
        desc.pre0 = CH_MINUS;
      end else if (force_plus) begin
        desc.plen = 2'd1;
        desc.pre0 = CH_PLUS;
      end else if (space_sign) begin
        desc.plen = 2'd1;
        desc.pre0 = CH_SPACE;
      end
    end else if ((conversion == CONV_PTR) || (hexc && alt_form && mag != 64'd0)) begin
      desc.plen = 2'd2;
    end
    desc.left    = left_justify;
    desc.zf      = zero_fill && !left_justify && !digits_given;
    desc.alt_oct = (conversion == CONV_OCT) && alt_form;
    desc.width   = min_width;
    desc.prec    = min_digits;
    desc.given   = digits_given;
  end

endmodule

>>> rtl/iff_queue.sv
// iff_queue: two-entry descriptor queue between front and back
// depends on iff_pkg
module iff_queue import iff_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  desc_t      push_data,
  output logic       full,
  input  logic       pop,
  output desc_t      pop_data,
  output logic       empty,
  output logic [1:0] count
);

  desc_t      q_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign count    = cnt_r;
  assign pop_data = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/iff_back.sv
// iff_back: digit conversion (double dabble for decimal), field layout and character emission
// depends on iff_pkg; holds the output register of the result channel
module iff_back import iff_pkg::*; #(
  parameter int MAX_FIELD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       empty,
  input  desc_t      job,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [6:0] out_char,
  output logic       out_last
);

  typedef enum logic [2:0] {ST_IDLE, ST_CONV, ST_SIZE, ST_PAD, ST_LAY, ST_EMIT} state_t;

  state_t             state_r;
  desc_t              d_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [63:0]        sh_r;
  logic [5:0]         cnt_r;
  logic [3:0]         dig_r [NDIG];
  logic [4:0]         nd_r;
  logic [5:0]         zeros_r;
  logic [6:0]         pad_r;
  logic [7:0]         b1_r, b2_r, b4_r, b5_r, i_r;
  logic               out_valid_r, out_last_r;
  logic [6:0]         out_char_r;

  logic [BCD_W-1:0]   adj;
  logic [BCD_W+63:0]  shifted;
  logic [65:0]        oext;
  logic [4*NDIG-1:0]  hext, bcdx;
  logic [3:0]         dsrc [NDIG];
  logic [4:0]         top, nd_c, idx;
  logic [5:0]         zeros_c;
  logic [7:0]         core, padw, b3, len, n_c, ip1;
  logic [6:0]         ch;
  logic               fire;

  assign pop        = (state_r == ST_IDLE) && !empty;
  assign fire       = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;

  always_comb begin
    for (int k = 0; k < BCD_W / 4; k++) begin
      adj[4*k +: 4] = (bcd_r[4*k +: 4] >= 4'd5) ? bcd_r[4*k +: 4] + 4'd3 : bcd_r[4*k +: 4];
    end
    shifted = {adj, sh_r} << 1;
    bcdx    = {{(4*NDIG-BCD_W){1'b0}}, shifted[BCD_W+63:64]};
    oext    = {2'b0, job.mag};
    hext    = {{(4*NDIG-64){1'b0}}, job.mag};
    for (int k = 0; k < NDIG; k++) begin
      dsrc[k] = (job.base == BASE_OCT) ? {1'b0, oext[3*k +: 3]} : hext[4*k +: 4];
    end
  end

  always_comb begin
    top = 5'd1;
    for (int k = 1; k < NDIG; k++) begin
      if (dig_r[k] != 4'd0) top = 5'(k + 1);
    end
    nd_c = (d_r.given && d_r.prec == 6'd0 && d_r.mag_zero && !d_r.ptr) ? 5'd0 : top;
    zeros_c = (d_r.given && d_r.prec > {1'b0, nd_c}) ? d_r.prec - {1'b0, nd_c} : 6'd0;
    if (d_r.alt_oct && zeros_c == 6'd0 && (nd_c == 5'd0 || !d_r.mag_zero)) zeros_c = 6'd1;
  end

  always_comb begin
    core = {6'b0, d_r.plen} + {2'b0, zeros_r} + {3'b0, nd_r};
    padw = ({1'b0, d_r.width} > core) ? {1'b0, d_r.width} - core : 8'd0;
    b3   = b2_r + (d_r.zf ? {1'b0, pad_r} : 8'd0);
    len  = b5_r + (d_r.left ? {1'b0, pad_r} : 8'd0);
    n_c  = (len > 8'(MAX_FIELD)) ? 8'(MAX_FIELD) : len;
    ip1  = i_r + 8'd1;
    idx  = 5'(b5_r - ip1);
    if (i_r < b1_r) ch = CH_SPACE;
    else if (i_r < b2_r) ch = (i_r == b1_r) ? d_r.pre0 : d_r.pre1;
    else if (i_r < b4_r) ch = CH_ZERO;
    else if (i_r < b5_r) ch = digit_char(dig_r[idx], d_r.upper);
    else ch = CH_SPACE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) out_valid_r <= (n_c != 8'd0);
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!empty) begin
            d_r   <= job;
            sh_r  <= job.mag;
            bcd_r <= '0;
            cnt_r <= 6'd0;
            dig_r <= dsrc;
            state_r <= (job.base == BASE_DEC) ? ST_CONV : ST_SIZE;
          end
        end
        ST_CONV: begin
          bcd_r <= shifted[BCD_W+63:64];
          sh_r  <= shifted[63:0];
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            for (int k = 0; k < NDIG; k++) begin
              dig_r[k] <= bcdx[4*k +: 4];
            end
            state_r <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          nd_r    <= nd_c;
          zeros_r <= zeros_c;
          state_r <= ST_PAD;
        end
        ST_PAD: begin
          pad_r <= padw[6:0];
          b1_r  <= (!d_r.left && !d_r.zf) ? padw : 8'd0;
          b2_r  <= ((!d_r.left && !d_r.zf) ? padw : 8'd0) + {6'b0, d_r.plen};
          state_r <= ST_LAY;
        end
        ST_LAY: begin
          b4_r <= b3 + {2'b0, zeros_r};
          b5_r <= b3 + {2'b0, zeros_r} + {3'b0, nd_r};
          i_r  <= 8'd0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (fire) begin
            if (n_c != 8'd0) begin
              out_char_r <= ch;
              out_last_r <= (ip1 == n_c);
              i_r        <= ip1;
              if (ip1 == n_c) state_r <= ST_IDLE;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> tb/tb.sv
// tb: self-checking bench for integer_field_formatter_top, printf-style integer fields
// depends on iff_pkg and integer_field_formatter_top; directed table first, then random
// bursts, every character compared with a predictor written here
module tb;
  import iff_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic [2:0]  conv;
    logic [1:0]  size;
    logic        left;
    logic        plus;
    logic        space;
    logic        zero;
    logic        alt;
    logic [6:0]  width;
    logic [5:0]  prec;
    logic        given;
  } spec_t;

  typedef struct {
    spec_t s;
    string want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [4:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  logic [7:0] char_q[$];
  int  errors = 0;
  int  chars_seen = 0;
  int  fields_sent = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  done = 1'b0;

  integer_field_formatter_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // character stream the field should produce, {last, char}
  function automatic void format_field(input spec_t s, ref logic [7:0] q[$]);
    int bits, base, nd, zeros, plen, core, pad;
    logic [63:0] mask, raw, mag, v;
    logic neg, zf;
    logic [6:0] pre[2];
    logic [6:0] buff[$];
    logic [6:0] rev[$];
    logic [3:0] d;
    buff = {};
    rev = {};
    neg = 1'b0;
    plen = 0;
    zeros = 0;
    if (s.conv > CONV_PTR) return;
    bits = (s.size == SIZE_32) ? 32 : (s.size == SIZE_16) ? 16 : 64;
    if (s.conv == CONV_PTR) bits = 64;
    mask = (bits == 64) ? '1 : ((64'd1 << bits) - 1);
    raw = s.value & mask;
    mag = raw;
    if (s.conv == CONV_SDEC && raw[bits-1]) begin
      neg = 1'b1;
      mag = (64'd0 - raw) & mask;
    end
    base = (s.conv == CONV_OCT) ? 8 : (s.conv >= CONV_HEXL) ? 16 : 10;
    v = mag;
    do begin
      d = 4'(v % base);
      if (d < 10) rev.push_back(7'h30 + d);
      else if (s.conv == CONV_HEXU) rev.push_back(7'h37 + d);
      else rev.push_back(7'h57 + d);
      v = v / base;
    end while (v != 0);
    nd = rev.size();
    if (s.given && s.prec == 0 && mag == 0 && s.conv != CONV_PTR) nd = 0;
    if (s.given && s.prec > nd) zeros = s.prec - nd;
    if (s.conv == CONV_OCT && s.alt && zeros == 0 && (nd == 0 || mag != 0)) zeros = 1;
    if (s.conv == CONV_SDEC) begin
      if (neg) pre[plen++] = CH_MINUS;
      else if (s.plus) pre[plen++] = CH_PLUS;
      else if (s.space) pre[plen++] = CH_SPACE;
    end else if (s.conv == CONV_PTR ||
                 ((s.conv == CONV_HEXL || s.conv == CONV_HEXU) && s.alt && mag != 0)) begin
      pre[plen++] = CH_ZERO;
      pre[plen++] = (s.conv == CONV_HEXU) ? CH_XU : CH_XL;
    end
    core = plen + zeros + nd;
    pad = (s.width > core) ? s.width - core : 0;
    zf = s.zero && !s.left && !s.given;
    if (!s.left && !zf) repeat (pad) buff.push_back(CH_SPACE);
    for (int i = 0; i < plen; i++) buff.push_back(pre[i]);
    if (zf) repeat (pad) buff.push_back(CH_ZERO);
    repeat (zeros) buff.push_back(CH_ZERO);
    for (int i = nd; i > 0; i--) buff.push_back(rev[i-1]);
    if (s.left) repeat (pad) buff.push_back(CH_SPACE);
    if (buff.size() > 64) buff = buff[0:63];
    foreach (buff[i]) q.push_back({(i == buff.size() - 1), buff[i]});
  endfunction

  function automatic spec_t mk(input logic [63:0] value, input logic [2:0] conv,
                               input logic [1:0] size, input logic [6:0] flags,
                               input logic [6:0] width, input logic [5:0] prec);
    spec_t s;
    s.value = value;
    s.conv = conv;
    s.size = size;
    {s.given, s.alt, s.zero, s.space, s.plus, s.left} = flags[5:0];
    s.width = width;
    s.prec = prec;
    return s;
  endfunction

  function automatic spec_t rand_spec();
    spec_t s;
    s.value = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: s.value = 64'($urandom_range(0, 20));
      1: s.value = s.value | 64'h8000_0000_8000_8000;
      default: ;
    endcase
    s.conv = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    s.size = 2'($urandom_range(0, 3));
    {s.left, s.plus, s.space, s.zero, s.alt, s.given} = 6'($urandom);
    s.width = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(30, 64)) : 7'($urandom_range(0, 24));
    s.prec = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(30, 63)) : 6'($urandom_range(0, 12));
    return s;
  endfunction

  // one field beat, waits for acceptance and queues its characters
  task automatic send_field(input spec_t s);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, s.given, s.prec, s.width, s.alt, s.zero, s.space, s.plus, s.left,
                 s.value};
    in_tuser <= {s.size, s.conv};
    do @(posedge clk); while (!in_tready);
    format_field(s, char_q);
    fields_sent++;
  endtask

  function automatic void check_row(input row_t r);
    logic [7:0] q[$];
    format_field(r.s, q);
    if (q.size() != r.want.len()) begin
      errors++;
      $display("table row len mismatch: want \"%s\" predicted %0d", r.want, q.size());
    end else
      foreach (q[i])
        if (q[i][6:0] != r.want[i]) begin
          errors++;
          $display("table row mismatch: want \"%s\" at %0d", r.want, i);
          break;
        end
  endfunction

  row_t rows[$];

  initial begin
    // flags: {given, alt, zero, space, plus, left}
    rows = '{
      '{mk(64'd0, CONV_SDEC, SIZE_32, 7'b0, 0, 0), "0"},
      '{mk(64'h8000_0000, CONV_SDEC, SIZE_32, 7'b0, 0, 0), "-2147483648"},
      '{mk(64'h8000, CONV_SDEC, SIZE_16, 7'b0, 0, 0), "-32768"},
      '{mk(64'h8000_0000_0000_0000, CONV_SDEC, 2'd2, 7'b0, 0, 0), "-9223372036854775808"},
      '{mk('1, CONV_UDEC, 2'd2, 7'b0, 0, 0), "18446744073709551615"},
      '{mk('1, CONV_UDEC, 2'd3, 7'b0, 0, 0), "18446744073709551615"},
      '{mk('1, CONV_OCT, 2'd2, 7'b0, 0, 0), "1777777777777777777777"},
      '{mk(64'd8, CONV_OCT, SIZE_32, 7'b010000, 0, 0), "010"},
      '{mk(64'd0, CONV_OCT, SIZE_32, 7'b110000, 0, 0), "0"},
      '{mk(64'd255, CONV_HEXL, SIZE_32, 7'b010000, 0, 0), "0xff"},
      '{mk(64'd255, CONV_HEXU, SIZE_32, 7'b010000, 0, 0), "0XFF"},
      '{mk(64'd0, CONV_HEXL, SIZE_32, 7'b010000, 0, 0), "0"},
      '{mk(64'd0, CONV_HEXL, SIZE_32, 7'b100000, 0, 0), ""},
      '{mk(64'd0, CONV_PTR, SIZE_16, 7'b100000, 0, 0), "0x0"},
      '{mk(64'd5, CONV_SDEC, SIZE_32, 7'b000010, 0, 0), "+5"},
      '{mk(64'd5, CONV_SDEC, SIZE_32, 7'b000100, 0, 0), " 5"},
      '{mk(64'd5, CONV_UDEC, SIZE_32, 7'b000110, 0, 0), "5"},
      '{mk(64'hffff_ffff, CONV_SDEC, SIZE_32, 7'b001000, 5, 0), "-0001"},
      '{mk(64'd26, CONV_HEXL, SIZE_32, 7'b011000, 6, 0), "0x001a"},
      '{mk(64'd7, CONV_SDEC, SIZE_32, 7'b000001, 3, 0), "7  "},
      '{mk(64'd7, CONV_SDEC, SIZE_32, 7'b101000, 4, 2), "  07"},
      '{mk(64'd1, CONV_UDEC, SIZE_32, 7'b100000, 64, 61), ""},
      '{mk(64'd9, 3'd6, SIZE_32, 7'b0, 3, 0), ""},
      '{mk(64'd9, 3'd7, SIZE_32, 7'b0, 3, 0), ""},
      '{mk('1, CONV_PTR, SIZE_32, 7'b111111, 64, 63), ""}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // rows with an empty wanted string, nonzero width and a known conversion are predictor-checked only
    foreach (rows[i]) begin
      if (rows[i].want.len() != 0 || rows[i].s.width == 0 || rows[i].s.conv > CONV_PTR)
        check_row(rows[i]);
      send_field(rows[i].s);
    end
    in_tvalid <= 1'b0;
    // keep offering while the receiver holds off
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (6) send_field(rand_spec());
    join
    in_tvalid <= 1'b0;
    while (fields_sent < 320) begin
      int burst;
      burst = $urandom_range(1, 12);
      repeat (burst) send_field(rand_spec());
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    done = 1'b1;
  end

  // receiver stall pattern: alternating ready runs and stall runs
  initial begin
    int run;
    @(posedge rst_n);
    forever begin
      run = $urandom_range(1, 30);
      repeat (run) begin
        out_tready <= !hold_off;
        @(posedge clk);
      end
      run = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      repeat (run) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      chars_seen++;
      if (char_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected char %h last %b", out_tdata, out_tlast);
      end else begin
        logic [7:0] want;
        want = char_q.pop_front();
        if (out_tdata != {1'b0, want[6:0]} || out_tlast != want[7]) begin
          errors++;
          if (errors <= 10)
            $display("char mismatch: expected %h last %b, got %h last %b",
                     want[6:0], want[7], out_tdata, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (done || idle_cycles >= 5000);
    if (!done) begin
      $display("timeout, %0d chars still pending", char_q.size());
      $display("tb failed");
    end else begin
      $display("%0d fields formatted over all conversions and sizes, %0d chars checked",
               fields_sent, chars_seen);
      if (errors == 0 && char_q.size() == 0) begin
        $display("tb passed");
      end else begin
        $display("%0d mismatches", errors);
        $display("tb failed");
      end
    end
    $finish;
  end

endmodule
